>>> src/bus_plug_and_play_capture_top_macros.svh
// Assertion helpers used by the capture block's control module (bpnp_ctrl).
// Each one is clocked on i_clk and quiet while i_rst_n is low.
`ifndef BUS_PLUG_AND_PLAY_CAPTURE_TOP_MACROS_SVH
`define BUS_PLUG_AND_PLAY_CAPTURE_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BPNP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BPNP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/bpnp_pkg.sv
package bpnp_pkg;

    localparam int AHB_MASTER_SLOTS = 16;
    localparam int AHB_SLAVE_SLOTS  = 64;
    localparam int APB_SLOTS        = 64;
    localparam int AHB_BANKS        = 4;

    localparam int AHB_SLOTS  = AHB_MASTER_SLOTS + AHB_SLAVE_SLOTS;
    localparam int NSLOTS     = AHB_SLOTS + APB_SLOTS;
    localparam int NBANKWORDS = AHB_SLOTS * AHB_BANKS + APB_SLOTS;

    localparam int SLOT_AW = $clog2(NSLOTS);
    localparam int BANK_AW = $clog2(NBANKWORDS);
    localparam int SLOT_CW = 7;   // holds a slot count of up to 64
    localparam int BANK_KW = (AHB_BANKS > 1) ? $clog2(AHB_BANKS) : 1;

    // Bus codes
    localparam logic [1:0] BUS_AHB_MST = 2'd0;
    localparam logic [1:0] BUS_AHB_SLV = 2'd1;
    localparam logic [1:0] BUS_APB     = 2'd2;

    // Action codes
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_CAPTURE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_TAKEN     = 2'd2;

    // Configuration register indexes
    localparam int         CFG_AW                 = 3;
    localparam logic [0:0] CFG_IDX_APB_AREA_BASE  = 1'd0;
    localparam logic [31:0] APB_AREA_BASE_RESET   = 32'h8000_0000;

    typedef struct packed {
        logic        action;
        logic [1:0]  bus;
        logic [5:0]  slot_index;
        logic [2:0]  word_select;
        logic [31:0] word_data;
        logic [7:0]  vendor_code;
        logic [11:0] device_code;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_slot;
        logic [4:0]  irq_line;
        logic [4:0]  core_version;
        logic        bar_used;
        logic [31:0] bar_start;
        logic        prefetchable;
        logic        cacheable;
        logic [11:0] bar_mask;
        logic [3:0]  bar_type;
        logic        last;
    } t_out_word;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_BANK_RD,
        S_BANK_OUT,
        S_FAIL_MISS,
        S_FAIL_TAKEN
    } t_state;

    typedef struct packed {
        logic       clr_en;
        logic       load_en;
        logic       cap_start;
        logic       scan_en;
        logic       lock_set;
        logic       bank_rd;
        logic       bank_next;
        logic       out_bank;
        logic       out_fail;
        logic [1:0] fail_code;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic hit;
        logic hit_locked;
        logic miss;
        logic bank_last;
        logic out_free;
    } t_stat;

    function automatic logic [SLOT_CW-1:0] bus_slots(input logic [1:0] bus);
        logic [SLOT_CW-1:0] n;
        case (bus)
            BUS_AHB_MST: n = SLOT_CW'(AHB_MASTER_SLOTS);
            BUS_AHB_SLV: n = SLOT_CW'(AHB_SLAVE_SLOTS);
            BUS_APB:     n = SLOT_CW'(APB_SLOTS);
            default:     n = '0;
        endcase
        return n;
    endfunction

    function automatic logic [SLOT_AW-1:0] bus_first(input logic [1:0] bus);
        logic [SLOT_AW-1:0] f;
        case (bus)
            BUS_AHB_MST: f = '0;
            BUS_AHB_SLV: f = SLOT_AW'(AHB_MASTER_SLOTS);
            default:     f = SLOT_AW'(AHB_SLOTS);
        endcase
        return f;
    endfunction

    function automatic logic [2:0] bus_banks(input logic [1:0] bus);
        return (bus == BUS_APB) ? 3'd1 : 3'(AHB_BANKS);
    endfunction

    function automatic logic [BANK_AW-1:0] bank_pos(input logic [1:0] bus,
                                                    input logic [SLOT_AW-1:0] flat,
                                                    input logic [BANK_KW-1:0] k);
        logic [BANK_AW-1:0] p;
        if (bus == BUS_APB) begin
            p = BANK_AW'(AHB_SLOTS * AHB_BANKS) + BANK_AW'(flat) - BANK_AW'(AHB_SLOTS);
        end else begin
            p = BANK_AW'(flat) * BANK_AW'(AHB_BANKS) + BANK_AW'(k);
        end
        return p;
    endfunction

endpackage

>>> src/bpnp_cfg.sv
module bpnp_cfg
    import bpnp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [31:0]       o_apb_area_base
);

    logic [31:0] r_apb_area_base;
    logic        sel_base;

    assign sel_base = (paddr[CFG_AW-1:2] == CFG_IDX_APB_AREA_BASE);
    assign pready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_apb_area_base <= APB_AREA_BASE_RESET;
        end else if (psel && penable && pwrite && sel_base) begin
            r_apb_area_base <= pwdata;
        end
    end

    assign prdata          = sel_base ? r_apb_area_base : '0;
    assign o_apb_area_base = r_apb_area_base;

endmodule

>>> src/bpnp_ctrl.sv
module bpnp_ctrl
    import bpnp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_action,
    output logic  o_in_stall,
    output t_cmd  o_cmd,
    input  t_stat i_stat
);

    `include "bus_plug_and_play_capture_top_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   in_accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_action == ACT_LOAD) begin
                        o_cmd.load_en = 1'b1;
                    end else begin
                        o_cmd.cap_start = 1'b1;
                        n_state         = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_en = 1'b1;
                if (i_stat.hit) begin
                    if (i_stat.hit_locked) begin
                        n_state = S_FAIL_TAKEN;
                    end else begin
                        o_cmd.lock_set = 1'b1;
                        n_state        = S_BANK_RD;
                    end
                end else if (i_stat.miss) begin
                    n_state = S_FAIL_MISS;
                end
            end
            S_BANK_RD: begin
                o_cmd.bank_rd = 1'b1;
                n_state       = S_BANK_OUT;
            end
            S_BANK_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_bank = 1'b1;
                    if (i_stat.bank_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.bank_next = 1'b1;
                        n_state         = S_BANK_RD;
                    end
                end
            end
            S_FAIL_MISS: begin
                o_cmd.fail_code = STATUS_NOT_FOUND;
                if (i_stat.out_free) begin
                    o_cmd.out_fail = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_FAIL_TAKEN: begin
                o_cmd.fail_code = STATUS_TAKEN;
                if (i_stat.out_free) begin
                    o_cmd.out_fail = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `BPNP_ASSERT_SAME(a_no_overwrite, o_cmd.out_bank || o_cmd.out_fail, i_stat.out_free, "result word overwritten while pending")
    `BPNP_ASSERT_SAME(a_bank_past_last, o_cmd.bank_next, !i_stat.bank_last, "bank index advanced past the last bank")
    `BPNP_ASSERT_SAME(a_clear_blocks_input, o_cmd.clr_en, o_in_stall, "input accepted during the clearing pass")
    `BPNP_ASSERT_NEXT(a_lock_then_bank, o_cmd.lock_set, r_state == S_BANK_RD, "slot locked without bank readout")

endmodule

>>> src/bpnp_dpath.sv
module bpnp_dpath
    import bpnp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  t_in_word    i_in_word,
    input  logic [31:0] i_apb_area_base,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    // Tables
    logic [31:0] ident_mem [NSLOTS];
    logic [31:0] bank_mem  [NBANKWORDS];
    logic        lock_mem  [NSLOTS];

    // Clearing pass
    logic [BANK_AW-1:0] r_clr_addr;
    logic               clr_ident;

    // Capture context
    logic [1:0]         r_bus;
    logic [7:0]         r_ven;
    logic [11:0]        r_dev;
    logic [SLOT_CW-1:0] r_issue;
    logic               r_rd_valid;
    logic [5:0]         r_rd_idx;
    logic [31:0]        r_id_rd;
    logic               r_lock_rd;
    logic [5:0]         r_hit_slot;
    logic [31:0]        r_hit_id;
    logic [BANK_KW-1:0] r_k;
    logic [31:0]        r_bank_rd;

    logic [SLOT_CW-1:0] cap_count;
    logic [SLOT_AW-1:0] cap_first;
    logic [SLOT_AW-1:0] scan_addr;
    logic [SLOT_AW-1:0] rd_flat;
    logic [SLOT_AW-1:0] hit_flat;
    logic               match;
    logic               scan_issue;
    logic [BANK_AW-1:0] bank_raddr;
    logic [2:0]         cap_banks;

    // Load decode
    logic [SLOT_CW-1:0] ld_count;
    logic [SLOT_AW-1:0] ld_flat;
    logic               ld_ok;
    logic               ld_ident;
    logic               ld_bank;
    logic [BANK_AW-1:0] ld_bank_addr;

    // Memory write ports
    logic               ident_we;
    logic [SLOT_AW-1:0] ident_waddr;
    logic [31:0]        ident_wdata;
    logic               bank_we;
    logic [BANK_AW-1:0] bank_waddr;
    logic [31:0]        bank_wdata;
    logic               lock_we;
    logic [SLOT_AW-1:0] lock_waddr;
    logic               lock_wdata;

    // Output register
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word bank_word;
    t_out_word fail_word;

    assign clr_ident = (r_clr_addr < BANK_AW'(NSLOTS));

    assign ld_count     = bus_slots(i_in_word.bus);
    assign ld_ok        = (SLOT_CW'(i_in_word.slot_index) < ld_count);
    assign ld_flat      = bus_first(i_in_word.bus) + SLOT_AW'(i_in_word.slot_index);
    assign ld_ident     = i_cmd.load_en && ld_ok && (i_in_word.word_select == 3'd0);
    assign ld_bank      = i_cmd.load_en && ld_ok && (i_in_word.word_select != 3'd0)
                          && (i_in_word.word_select <= bus_banks(i_in_word.bus));
    assign ld_bank_addr = bank_pos(i_in_word.bus, ld_flat,
                                   BANK_KW'(i_in_word.word_select - 3'd1));

    assign cap_count  = bus_slots(r_bus);
    assign cap_first  = bus_first(r_bus);
    assign cap_banks  = bus_banks(r_bus);
    assign scan_addr  = cap_first + SLOT_AW'(r_issue[5:0]);
    assign rd_flat    = cap_first + SLOT_AW'(r_rd_idx);
    assign hit_flat   = cap_first + SLOT_AW'(r_hit_slot);
    assign match      = r_rd_valid && (r_id_rd[31:24] == r_ven) && (r_id_rd[23:12] == r_dev);
    assign scan_issue = i_cmd.scan_en && !match && (r_issue < cap_count);
    assign bank_raddr = bank_pos(r_bus, hit_flat, r_k);

    assign ident_we    = i_cmd.clr_en ? clr_ident : ld_ident;
    assign ident_waddr = i_cmd.clr_en ? SLOT_AW'(r_clr_addr) : ld_flat;
    assign ident_wdata = i_cmd.clr_en ? '0 : i_in_word.word_data;
    assign bank_we     = i_cmd.clr_en || ld_bank;
    assign bank_waddr  = i_cmd.clr_en ? r_clr_addr : ld_bank_addr;
    assign bank_wdata  = i_cmd.clr_en ? '0 : i_in_word.word_data;
    assign lock_we     = i_cmd.clr_en ? clr_ident : i_cmd.lock_set;
    assign lock_waddr  = i_cmd.clr_en ? SLOT_AW'(r_clr_addr) : rd_flat;
    assign lock_wdata  = !i_cmd.clr_en;

    always_ff @(posedge i_clk) begin
        if (ident_we) ident_mem[ident_waddr] <= ident_wdata;
        if (scan_issue) r_id_rd <= ident_mem[scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (lock_we) lock_mem[lock_waddr] <= lock_wdata;
        if (scan_issue) r_lock_rd <= lock_mem[scan_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bank_we) bank_mem[bank_waddr] <= bank_wdata;
        if (i_cmd.bank_rd) r_bank_rd <= bank_mem[bank_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_rd_valid  <= 1'b0;
            r_issue     <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_en) r_clr_addr <= r_clr_addr + 1'b1;
            if (i_cmd.cap_start) begin
                r_issue    <= '0;
                r_rd_valid <= 1'b0;
                r_k        <= '0;
            end else begin
                r_rd_valid <= scan_issue;
                if (scan_issue) r_issue <= r_issue + 1'b1;
                if (i_cmd.bank_next) r_k <= r_k + 1'b1;
            end
            if (i_cmd.out_bank || i_cmd.out_fail) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_start) begin
            r_bus <= i_in_word.bus;
            r_ven <= i_in_word.vendor_code;
            r_dev <= i_in_word.device_code;
        end
        if (scan_issue) r_rd_idx <= r_issue[5:0];
        if (i_cmd.scan_en && match) begin
            r_hit_slot <= r_rd_idx;
            r_hit_id   <= r_id_rd;
        end
        if (i_cmd.out_bank) begin
            r_out <= bank_word;
        end else if (i_cmd.out_fail) begin
            r_out <= fail_word;
        end
    end

    always_comb begin
        logic [11:0] mask;
        mask                   = r_bank_rd[15:4];
        bank_word              = '0;
        bank_word.status       = STATUS_OK;
        bank_word.found_slot   = r_hit_slot;
        bank_word.irq_line     = r_hit_id[4:0];
        bank_word.core_version = r_hit_id[9:5];
        bank_word.last         = (3'(r_k) == cap_banks - 3'd1);
        if (r_bus == BUS_APB) begin
            bank_word.bar_used  = 1'b1;
            bank_word.bar_start = i_apb_area_base | {12'd0, r_bank_rd[31:20] & mask, 8'd0};
            bank_word.bar_mask  = mask;
            bank_word.bar_type  = r_bank_rd[3:0];
        end else if (r_bank_rd != 32'd0) begin
            bank_word.bar_used     = 1'b1;
            bank_word.bar_start    = r_bank_rd & 32'hFFF0_0000;
            bank_word.prefetchable = r_bank_rd[17];
            bank_word.cacheable    = r_bank_rd[16];
            bank_word.bar_mask     = mask;
            bank_word.bar_type     = r_bank_rd[3:0];
        end
    end

    always_comb begin
        fail_word        = '0;
        fail_word.status = i_cmd.fail_code;
        fail_word.last   = 1'b1;
    end

    assign o_stat.clr_last   = (r_clr_addr == BANK_AW'(NBANKWORDS - 1));
    assign o_stat.hit        = match;
    assign o_stat.hit_locked = r_lock_rd;
    assign o_stat.miss       = !r_rd_valid && !(r_issue < cap_count);
    assign o_stat.bank_last  = (3'(r_k) == cap_banks - 3'd1);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

>>> src/bus_plug_and_play_capture_top.sv
// Load word: written to the tables when accepted, no result; the next word may follow at once.
// Capture word: the ident table is read one slot per cycle over one memory port;
// a hit on a free slot locks it, then each bank is read and sent as one result word.
// A miss answers once every slot of the bus has been read (at once for the unused bus code);
// every result word waits in the output register while the output stalls.
// Reset: synchronous, active low; then a clearing pass zeroes tables and locks.
module bus_plug_and_play_capture_top
    import bpnp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // Request words: table loads and capture requests
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_word          i_in_word,

    // Result words
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_word         o_out_word,

    // Register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    // Command and status between the sequencer and the table datapath
    t_cmd        cmd;
    t_stat       stat;
    logic [31:0] apb_area_base;

    // Hold the APB bridge base; it is ORed into every decoded APB start address.
    // The input stalls during the clearing pass; configuration writes are taken throughout.
    bpnp_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_apb_area_base (apb_area_base)
    );

    // Sequence clearing, loads, the slot scan, locking, the bank readout and fail results.
    // The input stalls in every state but idle, so one word is worked on at a time.
    bpnp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_action (i_in_word.action),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Tables, scan compare, bank decode and the output register.
    // The output register lets a finished result wait while the next word is taken.
    bpnp_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_in_word       (i_in_word),
        .i_apb_area_base (apb_area_base),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_word      (o_out_word)
    );

endmodule

>>> tb/sv/bus_plug_and_play_capture_top_tb.sv
`timescale 1ns / 1ps

module bus_plug_and_play_capture_top_tb;
    import bpnp_pkg::*;

    // Bus code that names no table; loads are dropped, captures miss.
    localparam logic [1:0] BUS_NONE   = 2'd3;
    localparam logic [2:0] WSEL_IDENT = 3'd0;
    localparam logic [CFG_AW-1:0] ADDR_APB_AREA_BASE =
        CFG_AW'({CFG_IDX_APB_AREA_BASE, 2'b00});
    localparam int PHASE_WORDS = 110;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_stim_row;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_in_word          i_in_word   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_word         o_out_word;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [CFG_AW-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Shadow copy of the slot tables, locks and APB area base.
    logic [31:0] shadow_ident [NSLOTS];
    logic [31:0] shadow_bank  [NBANKWORDS];
    bit          shadow_lock  [NSLOTS];
    logic [31:0] shadow_apb_base;

    t_out_word decoded [4];   // result words of the latest capture
    t_out_word pending [$];   // result words still owed by the block
    int        fail_cnt    = 0;
    int        applied_cnt = 0;
    int        stall_left  = 0;
    bit        quiet_run   = 1'b0;

    bus_plug_and_play_capture_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("[bus_plug_and_play_capture_top] ERROR");
        $finish;
    end

    // Random per-word wait; a quiet run holds both sides at full rate.
    function automatic int draw_gap();
        return quiet_run ? 0 : $urandom_range(0, 6);
    endfunction

    function automatic int slot_span(input logic [1:0] bus);
        case (bus)
            BUS_AHB_MST: return AHB_MASTER_SLOTS;
            BUS_AHB_SLV: return AHB_SLAVE_SLOTS;
            BUS_APB:     return APB_SLOTS;
            default:     return 0;
        endcase
    endfunction

    function automatic int slot_base(input logic [1:0] bus);
        case (bus)
            BUS_AHB_SLV: return AHB_MASTER_SLOTS;
            BUS_APB:     return AHB_SLOTS;
            default:     return 0;
        endcase
    endfunction

    // Apply one request word to the shadow tables. Fill decoded[] for a capture.
    // Return -1 for a dropped load, else the number of result words.
    function automatic int decode_capture(input t_in_word w);
        int          span;
        int          first;
        int          nb;
        int          hit;
        int          flat;
        int          bank_at;
        bit          found;
        logic [31:0] id;
        logic [31:0] bw;
        logic [11:0] msk;
        span  = slot_span(w.bus);
        first = slot_base(w.bus);
        nb    = (w.bus == BUS_APB) ? 1 : AHB_BANKS;
        if (w.action == ACT_LOAD) begin
            if (int'(w.slot_index) >= span || int'(w.word_select) > nb) return -1;
            flat = first + int'(w.slot_index);
            bank_at = (w.bus == BUS_APB) ? AHB_SLOTS * AHB_BANKS + int'(w.slot_index)
                                         : flat * AHB_BANKS;
            if (w.word_select == WSEL_IDENT) begin
                shadow_ident[flat] = w.word_data;
            end else begin
                shadow_bank[bank_at + int'(w.word_select) - 1] = w.word_data;
            end
            return 0;
        end
        found = 1'b0;
        hit   = 0;
        for (int s = 0; s < span && !found; s++) begin
            id = shadow_ident[first + s];
            if (id[31:24] == w.vendor_code && id[23:12] == w.device_code) begin
                found = 1'b1;
                hit   = s;
            end
        end
        foreach (decoded[k]) decoded[k] = '0;
        if (!found) begin
            decoded[0].status = STATUS_NOT_FOUND;
            decoded[0].last   = 1'b1;
            return 1;
        end
        flat = first + hit;
        if (shadow_lock[flat]) begin
            decoded[0].status = STATUS_TAKEN;
            decoded[0].last   = 1'b1;
            return 1;
        end
        shadow_lock[flat] = 1'b1;
        id = shadow_ident[flat];
        bank_at = (w.bus == BUS_APB) ? AHB_SLOTS * AHB_BANKS + hit : flat * AHB_BANKS;
        for (int k = 0; k < nb; k++) begin
            bw  = shadow_bank[bank_at + k];
            msk = bw[15:4];
            decoded[k].status       = STATUS_OK;
            decoded[k].found_slot   = 6'(hit);
            decoded[k].irq_line     = id[4:0];
            decoded[k].core_version = id[9:5];
            if (w.bus == BUS_APB) begin
                decoded[k].bar_used  = 1'b1;
                decoded[k].bar_start = shadow_apb_base | {12'h000, bw[31:20] & msk, 8'h00};
                decoded[k].bar_mask  = msk;
                decoded[k].bar_type  = bw[3:0];
            end else if (bw != 32'h0) begin
                decoded[k].bar_used     = 1'b1;
                decoded[k].bar_start    = {bw[31:20], 20'h00000};
                decoded[k].prefetchable = bw[17];
                decoded[k].cacheable    = bw[16];
                decoded[k].bar_mask     = msk;
                decoded[k].bar_type     = bw[3:0];
            end
            decoded[k].last = (k == nb - 1);
        end
        return nb;
    endfunction

    // Request word builders; fields the block ignores get random filler.
    function automatic t_in_word mk_ld(input logic [1:0] bus, input logic [5:0] slot,
                                       input logic [2:0] wsel, input logic [31:0] data);
        t_in_word w;
        w.action      = ACT_LOAD;
        w.bus         = bus;
        w.slot_index  = slot;
        w.word_select = wsel;
        w.word_data   = data;
        w.vendor_code = 8'($urandom);
        w.device_code = 12'($urandom);
        return w;
    endfunction

    function automatic t_in_word mk_cap(input logic [1:0] bus, input logic [7:0] ven,
                                        input logic [11:0] dev);
        t_in_word w;
        w.action      = ACT_CAPTURE;
        w.bus         = bus;
        w.slot_index  = 6'($urandom);
        w.word_select = 3'($urandom);
        w.word_data   = $urandom;
        w.vendor_code = ven;
        w.device_code = dev;
        return w;
    endfunction

    function automatic t_out_word fail_word(input logic [1:0] status);
        t_out_word r;
        r        = '0;
        r.status = status;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic logic [7:0] pick_vendor();
        case ($urandom_range(0, 4))
            0:       return 8'h00;
            1:       return 8'h01;
            2:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [11:0] pick_device();
        case ($urandom_range(0, 4))
            0:       return 12'h000;
            1:       return 12'h00C;
            2:       return 12'hFFF;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_bank();
        case ($urandom_range(0, 9))
            0, 1:    return 32'h0000_0000;
            2:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, hold it until taken, then book the results it owes.
    // A typed row books its own result word in place of the shadow's.
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word typed_res);
        int gap;
        int n;
        if ($urandom_range(0, 19) == 0) quiet_run = !quiet_run;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        n = decode_capture(w);
        if (n >= 0) applied_cnt++;
        if (typed) begin
            pending.push_back(typed_res);
        end else begin
            for (int k = 0; k < n; k++) pending.push_back(decoded[k]);
        end
    endtask

    // Drop valid, drain every owed word, then let a trailing load settle.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    // Write the APB area base, then read it back.
    task automatic write_apb_base(input logic [31:0] v);
        paddr   <= ADDR_APB_AREA_BASE;
        pwdata  <= v;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        shadow_apb_base = v;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== v) begin
            $error("apb_area_base readback: expected %h, got %h", v, prdata);
            fail_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Well-formed sequence: fill a slot, then capture what was put there.
    task automatic run_sequence();
        logic [1:0]  bus;
        logic [5:0]  slot;
        logic [7:0]  ven;
        logic [11:0] dev;
        int          nb;
        bus  = 2'($urandom_range(0, 2));
        slot = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 3))
                                           : 6'($urandom_range(0, slot_span(bus) - 1));
        ven  = pick_vendor();
        dev  = pick_device();
        nb   = (bus == BUS_APB) ? 1 : AHB_BANKS;
        send_word(mk_ld(bus, slot, WSEL_IDENT, {ven, dev, 12'($urandom)}), 1'b0, '0);
        for (int k = 1; k <= nb; k++) begin
            if ($urandom_range(0, 4) != 0)
                send_word(mk_ld(bus, slot, 3'(k), pick_bank()), 1'b0, '0);
        end
        send_word(mk_cap(bus, ven, dev), 1'b0, '0);
        if ($urandom_range(0, 4) == 0) send_word(mk_cap(bus, ven, dev), 1'b0, '0);
    endtask

    // Compare one result word field by field.
    task automatic check_word(input t_out_word got, input t_out_word exp);
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            fail_cnt++;
        end
        if (got.found_slot !== exp.found_slot) begin
            $error("found_slot: expected %0d, got %0d", exp.found_slot, got.found_slot);
            fail_cnt++;
        end
        if (got.irq_line !== exp.irq_line) begin
            $error("irq_line: expected %0d, got %0d", exp.irq_line, got.irq_line);
            fail_cnt++;
        end
        if (got.core_version !== exp.core_version) begin
            $error("core_version: expected %0d, got %0d", exp.core_version, got.core_version);
            fail_cnt++;
        end
        if (got.bar_used !== exp.bar_used) begin
            $error("bar_used: expected %0d, got %0d", exp.bar_used, got.bar_used);
            fail_cnt++;
        end
        if (got.bar_start !== exp.bar_start) begin
            $error("bar_start: expected %h, got %h", exp.bar_start, got.bar_start);
            fail_cnt++;
        end
        if (got.prefetchable !== exp.prefetchable) begin
            $error("prefetchable: expected %0d, got %0d", exp.prefetchable, got.prefetchable);
            fail_cnt++;
        end
        if (got.cacheable !== exp.cacheable) begin
            $error("cacheable: expected %0d, got %0d", exp.cacheable, got.cacheable);
            fail_cnt++;
        end
        if (got.bar_mask !== exp.bar_mask) begin
            $error("bar_mask: expected %h, got %h", exp.bar_mask, got.bar_mask);
            fail_cnt++;
        end
        if (got.bar_type !== exp.bar_type) begin
            $error("bar_type: expected %h, got %h", exp.bar_type, got.bar_type);
            fail_cnt++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %0d, got %0d", exp.last, got.last);
            fail_cnt++;
        end
    endtask

    // Result side: check each taken word, then hold stall for a drawn number of cycles.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $error("result word arrived with nothing owed");
                fail_cnt++;
            end else begin
                check_word(o_out_word, pending.pop_front());
            end
            stall_left = draw_gap();
        end else if (stall_left > 0) begin
            stall_left--;
        end
        i_out_stall <= (stall_left > 0);
    end

    initial begin
        t_stim_row   rows [$];
        logic [31:0] bases [4];
        int          target;
        int          pick;

        foreach (shadow_ident[i]) shadow_ident[i] = '0;
        foreach (shadow_bank[i]) shadow_bank[i] = '0;
        foreach (shadow_lock[i]) shadow_lock[i] = 1'b0;
        shadow_apb_base = APB_AREA_BASE_RESET;

        // Directed rows: empty tables, invalid bus, empty-slot match, relock,
        // all-ones ident and bank words, dropped loads, APB decode, last slots.
        rows.push_back('{mk_cap(BUS_AHB_MST, 8'hFF, 12'hFFF), 1'b1, fail_word(STATUS_NOT_FOUND)});
        rows.push_back('{mk_cap(BUS_NONE, 8'h00, 12'h000), 1'b1, fail_word(STATUS_NOT_FOUND)});
        rows.push_back('{mk_cap(BUS_AHB_MST, 8'h00, 12'h000), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_AHB_MST, 8'h00, 12'h000), 1'b1, fail_word(STATUS_TAKEN)});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, WSEL_IDENT, 32'hFFFF_F3FF), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd1, 32'hFFFF_FFFF), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd2, 32'h0000_0001), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd3, 32'h0003_0000), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd4, 32'hABC0_FFF0), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd5, 32'h1234_5678), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd15, 3'd7, 32'h8765_4321), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_AHB_MST, 8'hFF, 12'hFFF), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_MST, 6'd63, WSEL_IDENT, 32'h1234_5000), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_AHB_MST, 8'h12, 12'h345), 1'b1, fail_word(STATUS_NOT_FOUND)});
        rows.push_back('{mk_ld(BUS_NONE, 6'd0, WSEL_IDENT, 32'h1234_5000), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_APB, 6'd63, WSEL_IDENT, 32'hABCD_E3E0), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_APB, 6'd63, 3'd1, 32'hFFFF_FFFF), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_APB, 6'd63, 3'd2, 32'h0000_0000), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_APB, 8'hAB, 12'hCDE), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_APB, 8'h00, 12'h000), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_SLV, 6'd63, WSEL_IDENT, 32'h5A00_11FF), 1'b0, '0});
        rows.push_back('{mk_ld(BUS_AHB_SLV, 6'd63, 3'd4, 32'hFFF3_FFFF), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_AHB_SLV, 8'h5A, 12'h001), 1'b0, '0});
        rows.push_back('{mk_cap(BUS_AHB_SLV, 8'h5A, 12'h001), 1'b1, fail_word(STATUS_TAKEN)});

        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_FFFF;
        bases[2] = $urandom;
        bases[3] = APB_AREA_BASE_RESET;

        // Hold reset, then release; the clearing pass stalls the input on its own.
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

        // Random phases, one APB area base each.
        foreach (bases[p]) begin
            settle();
            write_apb_base(bases[p]);
            target = applied_cnt + PHASE_WORDS;
            while (applied_cnt < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 60) begin
                    run_sequence();
                end else if (pick < 85) begin
                    send_word(mk_cap(2'($urandom), pick_vendor(), pick_device()), 1'b0, '0);
                end else begin
                    send_word(mk_ld(2'($urandom), 6'($urandom), 3'($urandom), $urandom),
                              1'b0, '0);
                end
            end
        end

        settle();
        if (fail_cnt == 0) begin
            $display("[bus_plug_and_play_capture_top] OK");
        end else begin
            $display("[bus_plug_and_play_capture_top] ERROR");
        end
        $finish;
    end

endmodule
